/* hw/rtl/cdq_pkg.sv */
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int DEPTH = 16;
   localparam int POS_W = $clog2(DEPTH);
   localparam int CAP_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

   localparam logic [1:0] REQ_PUSH_HEAD = 2'd0;
   localparam logic [1:0] REQ_PUSH_TAIL = 2'd1;
   localparam logic [1:0] REQ_POP_HEAD  = 2'd2;
   localparam logic [1:0] REQ_POP_TAIL  = 2'd3;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } cmd_type;

   function automatic logic [POS_W-1:0] step_up(input logic [POS_W-1:0] p,
                                                input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] nxt;
      nxt = CAP_W'(p) + CAP_W'(1);
      return (nxt >= cap) ? '0 : nxt[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] step_down(input logic [POS_W-1:0] p,
                                                  input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] last;
      last = cap - CAP_W'(1);
      return (p == '0) ? last[POS_W-1:0] : p - POS_W'(1);
   endfunction

endpackage

/* hw/rtl/cdq_ctrl.sv */
`timescale 1ns / 1ps

module cdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cdq_pkg::cmd_type cmd
);
   import cdq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       can_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = accept;
      cmd.exec    = 1'b0;
      cmd.load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            if (can_load) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load) rsp_valid_in = 1'b1;
      else rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction did not enter execute");

   a_exec_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> state_ff == ST_READ)
      else $error("execute not followed by read");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("response raised outside read");

   a_no_load_over_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !cmd.load)
      else $error("response overwritten while stalled");

endmodule

/* hw/rtl/cdq_dpath.sv */
`timescale 1ns / 1ps

module cdq_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  cdq_pkg::cmd_type            cmd,
   input  logic [1:0]                  req_type,
   input  logic signed [31:0]          req_push_value,
   input  logic                        csr_write_enable,
   input  logic [4:0]                  csr_write_data,
   output logic                        rsp_success,
   output logic signed [31:0]          rsp_head_value,
   output logic signed [31:0]          rsp_tail_value,
   output logic                        rsp_now_empty,
   output logic                        rsp_now_full
);
   import cdq_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   logic [1:0]        type_ff;
   logic [DATA_W-1:0] value_ff;
   logic [POS_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic              ok_ff, ok_in;
   logic              wr_en;
   logic [POS_W-1:0]  wr_addr;
   logic              full_now;

   logic              succ_ff, oempty_ff, ofull_ff;
   logic [DATA_W-1:0] ohead_ff, otail_ff;

   assign full_now = !empty_ff && (step_up(tail_ff, cap_ff) == head_ff);

   always_comb begin
      if (csr_write_data == '0) cap_in = CAP_W'(1);
      else if (csr_write_data > CAP_RESET) cap_in = CAP_RESET;
      else cap_in = csr_write_data;
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      ok_in    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      case (type_ff)
         REQ_PUSH_HEAD, REQ_PUSH_TAIL: begin
            if (!full_now) begin
               ok_in = 1'b1;
               wr_en = 1'b1;
               if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  wr_addr  = '0;
               end else if (type_ff == REQ_PUSH_HEAD) begin
                  head_in = step_down(head_ff, cap_ff);
                  wr_addr = head_in;
               end else begin
                  tail_in = step_up(tail_ff, cap_ff);
                  wr_addr = tail_in;
               end
            end
         end
         REQ_POP_HEAD, REQ_POP_TAIL: begin
            if (!empty_ff) begin
               ok_in = 1'b1;
               if (head_ff == tail_ff) empty_in = 1'b1;
               else if (type_ff == REQ_POP_HEAD) head_in = step_up(head_ff, cap_ff);
               else tail_in = step_down(tail_ff, cap_ff);
            end
         end
         default: ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         cap_ff   <= CAP_RESET;
      end else begin
         if (cmd.exec) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
         if (csr_write_enable && empty_ff) cap_ff <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         value_ff <= req_push_value;
      end
      if (cmd.exec) ok_ff <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) mem[wr_addr] <= value_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         succ_ff   <= ok_ff;
         ohead_ff  <= empty_ff ? '1 : mem[head_ff];
         otail_ff  <= empty_ff ? '1 : mem[tail_ff];
         oempty_ff <= empty_ff;
         ofull_ff  <= full_now;
      end
   end

   assign rsp_success    = succ_ff;
   assign rsp_head_value = ohead_ff;
   assign rsp_tail_value = otail_ff;
   assign rsp_now_empty  = oempty_ff;
   assign rsp_now_full   = ofull_ff;

endmodule

/* hw/rtl/circular_deque_core.sv */
// circular_deque_core: fixed-capacity double-ended queue of 32-bit entries.
// Request channel (req_valid / req_stall): req_type selects push at head,
// push at tail, pop head or pop tail; req_push_value is stored by pushes.
// Response channel (rsp_valid / rsp_stall): one transaction per request with
// the success flag, head and tail values after the step (all ones when
// empty) and the empty and full flags.
// csr_write_enable / csr_write_data set the capacity in use (0 reads as 1,
// above the store depth reads as the depth); ignored unless the deque is empty.
// rsp_valid rises after the execute step (store write) and then the read step
// (store read into the response register). Requests do not overlap: the next
// is taken only after the read step, set by the controller sequence and the
// single-port write / registered read of the entry store.
// A finished response waiting under rsp_stall does not block the next request;
// that request is held in its read step until the response register is free.
// Reset (synchronous, active high) empties the deque, clears both positions
// and sets the capacity to the full store depth; store contents stay unknown.
`timescale 1ns / 1ps

module circular_deque_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_success,
   output logic signed [31:0] rsp_head_value,
   output logic signed [31:0] rsp_tail_value,
   output logic               rsp_now_empty,
   output logic               rsp_now_full,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);
   import cdq_pkg::*;

   cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cdq_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_push_value   (req_push_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_success      (rsp_success),
      .rsp_head_value   (rsp_head_value),
      .rsp_tail_value   (rsp_tail_value),
      .rsp_now_empty    (rsp_now_empty),
      .rsp_now_full     (rsp_now_full)
   );

endmodule
